>>> rtl/lcs_pkg.sv
// Shared types, constants and helpers for the link connect supervisor.
// No dependencies; compile first.
package lcs_pkg;

    // Sizing
    localparam int MAX_NETS   = 8;
    localparam int TIMER_BITS = 32;
    localparam int NET_IDX_W  = $clog2(MAX_NETS + 1);
    localparam int CFG_W      = 32;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam int CNT_CMP_W  = (NET_IDX_W > 4) ? NET_IDX_W : 4;
    localparam int CFG_IDX_W  = 3;

    // Input kinds
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Link status codes that the supervisor reacts to
    localparam logic [2:0] LINK_NO_SSID        = 3'd1;
    localparam logic [2:0] LINK_CONNECTED      = 3'd3;
    localparam logic [2:0] LINK_CONNECT_FAILED = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STA_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NETWORK_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TMO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_DELAY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECONNECT_DLY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_RETRY    = 3'd6;

    // Reported state codes
    localparam logic [2:0] CODE_IDLE       = 3'd0;
    localparam logic [2:0] CODE_CONNECTING = 3'd1;
    localparam logic [2:0] CODE_SETTLING   = 3'd2;
    localparam logic [2:0] CODE_CONNECTED  = 3'd3;
    localparam logic [2:0] CODE_ERROR      = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE       = 5'b00001,
        ST_CONNECTING = 5'b00010,
        ST_SETTLING   = 5'b00100,
        ST_CONNECTED  = 5'b01000,
        ST_ERROR      = 5'b10000
    } state_t;

    typedef struct packed {
        logic             sta_enable;
        logic [3:0]       network_count;
        logic [CFG_W-1:0] connect_timeout_ms;
        logic [CFG_W-1:0] grace_ms;
        logic [CFG_W-1:0] settle_delay_ms;
        logic [CFG_W-1:0] reconnect_delay_ms;
        logic [CFG_W-1:0] error_retry_ms;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [2:0] link_status;
    } item_t;

    typedef struct packed {
        logic       start_attempt;
        logic [2:0] attempt_index;
        logic       disconnect_cmd;
        logic       connected_event;
        logic       lost_event;
        logic       error_event;
        logic [2:0] state_code;
    } result_t;

    function automatic logic [2:0] state_to_code(state_t s);
        logic [2:0] code;
        code = CODE_IDLE;
        unique case (s)
            ST_IDLE:       code = CODE_IDLE;
            ST_CONNECTING: code = CODE_CONNECTING;
            ST_SETTLING:   code = CODE_SETTLING;
            ST_CONNECTED:  code = CODE_CONNECTED;
            ST_ERROR:      code = CODE_ERROR;
            default:       code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/lcs_if.sv
// Valid/ready channel interfaces for the link connect supervisor.
// No dependencies.
interface lcs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [2:0] link_status;

    modport source (output valid, output kind, output link_status, input ready);
    modport sink   (input valid, input kind, input link_status, output ready);
endinterface

interface lcs_out_if;
    logic       valid;
    logic       ready;
    logic       start_attempt;
    logic [2:0] attempt_index;
    logic       disconnect_cmd;
    logic       connected_event;
    logic       lost_event;
    logic       error_event;
    logic [2:0] state_code;

    modport source (output valid, output start_attempt, output attempt_index,
                    output disconnect_cmd, output connected_event, output lost_event,
                    output error_event, output state_code, input ready);
    modport sink   (input valid, input start_attempt, input attempt_index,
                    input disconnect_cmd, input connected_event, input lost_event,
                    input error_event, input state_code, output ready);
endinterface

interface lcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/link_connect_supervisor_core.sv
// Link connect supervisor top level: input register, state machine, result register.
// Depends on lcs_pkg, lcs_if, lcs_cfg_regs and lcs_fsm.
//
// Usage:
//   in_ch carries one beat per millisecond tick (kind 0, with link_status) or a
//   restart (kind 1). Every input beat yields exactly one result beat on out_ch:
//   start/disconnect commands, connected/lost/error events, the network index
//   and the state after the beat.
//   cfg_ch writes one register per beat (index 0..6); other indexes are dropped.
//   Write only while no input beat is still in flight.
// Data path and throughput:
//   A beat sits in the input register, is processed by the state machine
//   and lands in the result register, which drives out_ch.valid. One beat
//   per cycle is sustained while out_ch.ready stays high; the limit is the
//   single state update per cycle in lcs_fsm.
// Reset:
//   rst_n clears the valid flags of both pipeline registers, the state machine
//   (idle, index 0, timer 0, no loss) and loads the register defaults.
// Stall:
//   When out_ch.ready is low while a result is pending, the result holds, a
//   full input register holds, and in_ch.ready drops once it is full.
module link_connect_supervisor_core (
    input  logic      clk,
    input  logic      rst_n,
    lcs_in_if.sink    in_ch,
    lcs_out_if.source out_ch,
    lcs_cfg_if.sink   cfg_ch
);
    import lcs_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_vld_reg;
    result_t res;
    result_t res_reg;
    logic    res_vld_reg;
    logic    advance;
    logic    step;

    lcs_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    lcs_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Pipeline flow control
    assign advance     = !res_vld_reg || out_ch.ready;
    assign step        = item_vld_reg && advance;
    assign in_ch.ready = !item_vld_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_vld_reg <= 1'b0;
        else if (in_ch.ready)
            item_vld_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            item_reg.kind        <= in_ch.kind;
            item_reg.link_status <= in_ch.link_status;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (advance)
            res_vld_reg <= item_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res;
    end

    // Drive the result beat
    assign out_ch.valid           = res_vld_reg;
    assign out_ch.start_attempt   = res_reg.start_attempt;
    assign out_ch.attempt_index   = res_reg.attempt_index;
    assign out_ch.disconnect_cmd  = res_reg.disconnect_cmd;
    assign out_ch.connected_event = res_reg.connected_event;
    assign out_ch.lost_event      = res_reg.lost_event;
    assign out_ch.error_event     = res_reg.error_event;
    assign out_ch.state_code      = res_reg.state_code;

endmodule

>>> rtl/lcs_cfg_regs.sv
// Configuration register file of the link connect supervisor.
// Depends on lcs_pkg and lcs_cfg_if.
module lcs_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    lcs_cfg_if.sink       cfg_ch,
    output lcs_pkg::cfg_t cfg
);
    import lcs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always ready: a write is registered straight into cfg_reg
    assign cfg_ch.ready = 1'b1;
    assign cfg          = cfg_reg;

    // Decode the register index; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                CFG_STA_ENABLE:    cfg_next.sta_enable         = cfg_ch.data[0];
                CFG_NETWORK_COUNT: cfg_next.network_count      = cfg_ch.data[3:0];
                CFG_CONNECT_TMO:   cfg_next.connect_timeout_ms = cfg_ch.data;
                CFG_GRACE:         cfg_next.grace_ms           = cfg_ch.data;
                CFG_SETTLE_DELAY:  cfg_next.settle_delay_ms    = cfg_ch.data;
                CFG_RECONNECT_DLY: cfg_next.reconnect_delay_ms = cfg_ch.data;
                CFG_ERROR_RETRY:   cfg_next.error_retry_ms     = cfg_ch.data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sta_enable         <= 1'b0;
            cfg_reg.network_count      <= 4'd0;
            cfg_reg.connect_timeout_ms <= 32'd10000;
            cfg_reg.grace_ms           <= 32'd1000;
            cfg_reg.settle_delay_ms    <= 32'd100;
            cfg_reg.reconnect_delay_ms <= 32'd5000;
            cfg_reg.error_retry_ms     <= 32'd30000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/lcs_fsm.sv
// Supervisor state machine: state, network index, phase timer, lost flag.
// Depends on lcs_pkg.
module lcs_fsm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  lcs_pkg::item_t  item,
    input  lcs_pkg::cfg_t   cfg,
    output lcs_pkg::result_t res
);
    import lcs_pkg::*;

    state_t                state_reg,   state_next;
    logic [NET_IDX_W-1:0]  net_idx_reg, net_idx_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic                  lost_reg,    lost_next;

    logic [NET_IDX_W-1:0]  count;
    logic [NET_IDX_W-1:0]  idx_inc;
    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]      t_ext;
    logic                  active;
    logic                  is_fail;

    // Effective list length, clamped to the table size
    always_comb
    begin
        if (CNT_CMP_W'(cfg.network_count) < CNT_CMP_W'(MAX_NETS))
            count = NET_IDX_W'(cfg.network_count);
        else
            count = NET_IDX_W'(MAX_NETS);
    end

    // Saturating phase timer
    assign elapsed_inc = (elapsed_reg == {TIMER_BITS{1'b1}}) ? elapsed_reg
                                                             : elapsed_reg + 1'b1;
    assign t_ext   = CMP_W'(elapsed_inc);
    assign idx_inc = net_idx_reg + 1'b1;
    assign active  = cfg.sta_enable && (count != '0);
    assign is_fail = (item.link_status == LINK_CONNECT_FAILED)
                  || (item.link_status == LINK_NO_SSID);

    // Next state and events for one beat
    always_comb
    begin
        state_next   = state_reg;
        net_idx_next = net_idx_reg;
        elapsed_next = elapsed_reg;
        lost_next    = lost_reg;
        res          = '0;

        if (item.kind == KIND_RESTART)
        begin
            state_next   = ST_IDLE;
            net_idx_next = '0;
            elapsed_next = '0;
            lost_next    = 1'b0;
        end
        else if (active)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    net_idx_next = '0;
                    elapsed_next = '0;
                    state_next   = ST_CONNECTING;
                    res.start_attempt = 1'b1;
                end
                ST_SETTLING:
                begin
                    elapsed_next = elapsed_inc;
                    if (t_ext >= CMP_W'(cfg.settle_delay_ms))
                    begin
                        net_idx_next = idx_inc;
                        elapsed_next = '0;
                        if (idx_inc >= count)
                        begin
                            state_next      = ST_ERROR;
                            res.error_event = 1'b1;
                        end
                        else
                        begin
                            state_next        = ST_CONNECTING;
                            res.start_attempt = 1'b1;
                        end
                    end
                end
                ST_CONNECTING:
                begin
                    elapsed_next = elapsed_inc;
                    if (item.link_status == LINK_CONNECTED)
                    begin
                        state_next          = ST_CONNECTED;
                        lost_next           = 1'b0;
                        res.connected_event = 1'b1;
                    end
                    else if ((t_ext > CMP_W'(cfg.grace_ms) && is_fail)
                          || t_ext > CMP_W'(cfg.connect_timeout_ms))
                    begin
                        res.disconnect_cmd = 1'b1;
                        state_next         = ST_SETTLING;
                        elapsed_next       = '0;
                    end
                end
                ST_CONNECTED:
                begin
                    if (lost_reg)
                        elapsed_next = elapsed_inc;
                    if (item.link_status != LINK_CONNECTED)
                    begin
                        if (!lost_reg)
                        begin
                            lost_next      = 1'b1;
                            elapsed_next   = '0;
                            res.lost_event = 1'b1;
                        end
                        else if (t_ext > CMP_W'(cfg.reconnect_delay_ms))
                        begin
                            lost_next  = 1'b0;
                            state_next = ST_IDLE;
                        end
                    end
                end
                ST_ERROR:
                begin
                    elapsed_next = elapsed_inc;
                    if (t_ext > CMP_W'(cfg.error_retry_ms))
                        state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end

        res.attempt_index = net_idx_next[2:0];
        res.state_code    = state_to_code(state_next);
    end

    // Commit on each processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            net_idx_reg <= '0;
            elapsed_reg <= '0;
            lost_reg    <= 1'b0;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            net_idx_reg <= net_idx_next;
            elapsed_reg <= elapsed_next;
            lost_reg    <= lost_next;
        end
    end

    // An attempt start opens a fresh connecting phase
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.start_attempt |=> state_reg == ST_CONNECTING && elapsed_reg == '0)
        else $error("attempt start did not open a fresh connecting phase");

    // At most one event per beat
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> $countones({res.start_attempt, res.disconnect_cmd, res.connected_event,
                             res.lost_event, res.error_event}) <= 1)
        else $error("more than one event in a beat");

    // State holds between beats
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(state_reg) && $stable(elapsed_reg) && $stable(net_idx_reg))
        else $error("state moved without a beat");

    // Settling always follows an attempt on a network inside the table
    a_settle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SETTLING |-> net_idx_reg < NET_IDX_W'(MAX_NETS))
        else $error("settling with an index past the list");

    // The loss flag is only meaningful while connected
    a_lost_scope: assert property (@(posedge clk) disable iff (!rst_n)
        lost_reg |-> state_reg == ST_CONNECTED)
        else $error("loss flag set outside the connected state");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for link_connect_supervisor_core: directed table, then random phases.
// Depends on lcs_pkg, lcs_if and the RTL; the table or a built-in predictor checks each beat.
module testbench;
    import lcs_pkg::*;

    // Link status codes not named in the package
    localparam logic [2:0] LINK_IDLE         = 3'd0;
    localparam logic [2:0] LINK_SCAN_DONE    = 3'd2;
    localparam logic [2:0] LINK_LOST         = 3'd5;
    localparam logic [2:0] LINK_DISCONNECTED = 3'd6;
    localparam logic [2:0] LINK_UNKNOWN      = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam int NUM_PHASES     = 12;
    localparam int PHASE_BEATS    = 150;
    localparam int SHORT_BEATS    = 20;
    localparam int HOLD_PHASE     = 3;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int QUIET_LIMIT    = 2000;

    typedef struct packed {
        logic                 is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          reg_data;
        item_t                pkt;
        logic                 typed;
        result_t              want;
    } step_t;

    logic clk;
    logic rst_n;

    lcs_in_if  in_bus();
    lcs_out_if out_bus();
    lcs_cfg_if cfg_bus();

    link_connect_supervisor_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus),
        .cfg_ch (cfg_bus)
    );

    // Predictor state and register copy
    cfg_t                  sup_cfg;
    state_t                sup_state;
    logic [3:0]            net_idx;
    logic [TIMER_BITS-1:0] elapsed;
    logic                  lost_seen;

    result_t    due_results[$];
    int         mismatch_count = 0;
    int         tx_mode = 1;
    int         rx_mode = 1;
    bit         rx_hold_req = 1'b0;
    logic [2:0] link_now = LINK_IDLE;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Per-beat wait: mode 0 never waits, 1 waits uniformly, 2 waits now and then
    function automatic int draw_gap(input int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return $urandom_range(0, 16);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    endfunction

    // Advance the millisecond timer, saturating at full scale
    function automatic void count_ms();
        if (elapsed != {TIMER_BITS{1'b1}})
            elapsed = elapsed + 1'b1;
    endfunction

    // Start on the current network, or raise an error once past the list
    function automatic void begin_attempt(input logic [3:0] n_eff, inout result_t r);
        elapsed = '0;
        if (net_idx >= n_eff)
        begin
            sup_state = ST_ERROR;
            r.error_event = 1'b1;
        end
        else
        begin
            sup_state = ST_CONNECTING;
            r.start_attempt = 1'b1;
        end
    endfunction

    // Expected result for one input beat; updates the predictor state
    function automatic result_t advance_link(input item_t pkt);
        result_t    r;
        logic [3:0] n_eff;
        r = '0;
        n_eff = (sup_cfg.network_count > 4'(MAX_NETS)) ? 4'(MAX_NETS) : sup_cfg.network_count;
        if (pkt.kind == KIND_RESTART)
        begin
            sup_state = ST_IDLE;
            net_idx   = '0;
            elapsed   = '0;
            lost_seen = 1'b0;
        end
        else if (sup_cfg.sta_enable && n_eff != 4'd0)
        begin
            case (sup_state)
                ST_IDLE:
                begin
                    net_idx = '0;
                    begin_attempt(n_eff, r);
                end
                ST_SETTLING:
                begin
                    count_ms();
                    if (elapsed >= sup_cfg.settle_delay_ms)
                    begin
                        net_idx = net_idx + 4'd1;
                        begin_attempt(n_eff, r);
                    end
                end
                ST_CONNECTING:
                begin
                    count_ms();
                    if (pkt.link_status == LINK_CONNECTED)
                    begin
                        sup_state = ST_CONNECTED;
                        lost_seen = 1'b0;
                        r.connected_event = 1'b1;
                    end
                    else if ((elapsed > sup_cfg.grace_ms &&
                              (pkt.link_status == LINK_CONNECT_FAILED ||
                               pkt.link_status == LINK_NO_SSID)) ||
                             elapsed > sup_cfg.connect_timeout_ms)
                    begin
                        r.disconnect_cmd = 1'b1;
                        sup_state = ST_SETTLING;
                        elapsed = '0;
                    end
                end
                ST_CONNECTED:
                begin
                    // the loss timer keeps running even if the link reads up again
                    if (lost_seen)
                        count_ms();
                    if (pkt.link_status != LINK_CONNECTED)
                    begin
                        if (!lost_seen)
                        begin
                            lost_seen = 1'b1;
                            elapsed = '0;
                            r.lost_event = 1'b1;
                        end
                        else if (elapsed > sup_cfg.reconnect_delay_ms)
                        begin
                            lost_seen = 1'b0;
                            sup_state = ST_IDLE;
                        end
                    end
                end
                ST_ERROR:
                begin
                    count_ms();
                    if (elapsed > sup_cfg.error_retry_ms)
                        sup_state = ST_IDLE;
                end
                default: sup_state = ST_IDLE;
            endcase
        end
        r.attempt_index = net_idx[2:0];
        case (sup_state)
            ST_CONNECTING: r.state_code = CODE_CONNECTING;
            ST_SETTLING:   r.state_code = CODE_SETTLING;
            ST_CONNECTED:  r.state_code = CODE_CONNECTED;
            ST_ERROR:      r.state_code = CODE_ERROR;
            default:       r.state_code = CODE_IDLE;
        endcase
        return r;
    endfunction

    // Mirror one register write into the predictor
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        case (idx)
            CFG_STA_ENABLE:    sup_cfg.sta_enable = value[0];
            CFG_NETWORK_COUNT: sup_cfg.network_count = value[3:0];
            CFG_CONNECT_TMO:   sup_cfg.connect_timeout_ms = value;
            CFG_GRACE:         sup_cfg.grace_ms = value;
            CFG_SETTLE_DELAY:  sup_cfg.settle_delay_ms = value;
            CFG_RECONNECT_DLY: sup_cfg.reconnect_delay_ms = value;
            CFG_ERROR_RETRY:   sup_cfg.error_retry_ms = value;
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Table row builders
    function automatic result_t mk_result(input logic start, input logic [2:0] idx,
                                          input logic disc, input logic conn, input logic lost,
                                          input logic err, input logic [2:0] code);
        result_t r;
        r.start_attempt   = start;
        r.attempt_index   = idx;
        r.disconnect_cmd  = disc;
        r.connected_event = conn;
        r.lost_event      = lost;
        r.error_event     = err;
        r.state_code      = code;
        return r;
    endfunction

    function automatic step_t mk_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        step_t s;
        s = '0;
        s.is_reg   = 1'b1;
        s.reg_idx  = idx;
        s.reg_data = value;
        return s;
    endfunction

    function automatic step_t mk_beat(input logic kind, input logic [2:0] status);
        step_t s;
        s = '0;
        s.pkt.kind        = kind;
        s.pkt.link_status = status;
        return s;
    endfunction

    function automatic step_t mk_checked(input logic kind, input logic [2:0] status,
                                         input result_t want);
        step_t s;
        s = mk_beat(kind, status);
        s.typed = 1'b1;
        s.want  = want;
        return s;
    endfunction

    // Offer one beat, wait for acceptance, queue its expected result
    task automatic send_beat(input item_t pkt, input logic typed, input result_t want);
        int      gap;
        result_t guess;
        gap = draw_gap(tx_mode);
        cfg_bus.valid <= 1'b0;
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.kind        <= pkt.kind;
        in_bus.link_status <= pkt.link_status;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        guess = advance_link(pkt);
        due_results.push_back(typed ? want : guess);
    endtask

    // Write one register; valid is dropped by the next input beat
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        apply_reg(idx, value);
    endtask

    // Hold input and wait until every expected result is back
    task automatic wait_quiet();
        in_bus.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_delay(input int phase);
        if (phase == 0)
            return 32'd0;
        if (phase == 1)
            return 32'hFFFF_FFFF;
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    // Stimulus
    initial
    begin : stimulus
        step_t      plan[$];
        item_t      pkt;
        bit         beat_since_reg;
        logic       en;
        logic [3:0] nets;
        int         phase;
        int         n;
        int         beats;

        in_bus.valid       <= 1'b0;
        in_bus.kind        <= KIND_TICK;
        in_bus.link_status <= LINK_IDLE;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= CFG_STA_ENABLE;
        cfg_bus.data       <= 32'd0;
        rst_n              <= 1'b0;

        sup_cfg.sta_enable         = 1'b0;
        sup_cfg.network_count      = 4'd0;
        sup_cfg.connect_timeout_ms = 32'd10000;
        sup_cfg.grace_ms           = 32'd1000;
        sup_cfg.settle_delay_ms    = 32'd100;
        sup_cfg.reconnect_delay_ms = 32'd5000;
        sup_cfg.error_retry_ms     = 32'd30000;
        sup_state = ST_IDLE;
        net_idx   = '0;
        elapsed   = '0;
        lost_seen = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Disabled after reset, restart, station on with an empty list
        plan.push_back(mk_checked(KIND_TICK, LINK_CONNECTED,
            mk_result(1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, CODE_IDLE)));
        plan.push_back(mk_checked(KIND_RESTART, LINK_IDLE,
            mk_result(1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, CODE_IDLE)));
        plan.push_back(mk_reg(CFG_STA_ENABLE, 32'd1));
        plan.push_back(mk_checked(KIND_TICK, LINK_CONNECT_FAILED,
            mk_result(1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, CODE_IDLE)));
        // Two networks, short timers; the unused index must be dropped
        plan.push_back(mk_reg(CFG_NETWORK_COUNT, 32'd2));
        plan.push_back(mk_reg(CFG_GRACE, 32'd2));
        plan.push_back(mk_reg(CFG_CONNECT_TMO, 32'd4));
        plan.push_back(mk_reg(CFG_SETTLE_DELAY, 32'd1));
        plan.push_back(mk_reg(CFG_RECONNECT_DLY, 32'd2));
        plan.push_back(mk_reg(CFG_ERROR_RETRY, 32'd1));
        plan.push_back(mk_reg(CFG_UNUSED, 32'hFFFF_FFFF));
        plan.push_back(mk_checked(KIND_TICK, LINK_IDLE,
            mk_result(1'b1, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, CODE_CONNECTING)));
        // Failure codes inside grace are ignored, then honored
        plan.push_back(mk_beat(KIND_TICK, LINK_CONNECT_FAILED));
        plan.push_back(mk_beat(KIND_TICK, LINK_NO_SSID));
        plan.push_back(mk_checked(KIND_TICK, LINK_CONNECT_FAILED,
            mk_result(1'b0, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, CODE_SETTLING)));
        plan.push_back(mk_checked(KIND_TICK, LINK_IDLE,
            mk_result(1'b1, 3'd1, 1'b0, 1'b0, 1'b0, 1'b0, CODE_CONNECTING)));
        // Plain not-connected codes run into the attempt timeout
        plan.push_back(mk_beat(KIND_TICK, LINK_SCAN_DONE));
        plan.push_back(mk_beat(KIND_TICK, LINK_LOST));
        plan.push_back(mk_beat(KIND_TICK, LINK_UNKNOWN));
        plan.push_back(mk_beat(KIND_TICK, LINK_DISCONNECTED));
        plan.push_back(mk_checked(KIND_TICK, LINK_IDLE,
            mk_result(1'b0, 3'd1, 1'b1, 1'b0, 1'b0, 1'b0, CODE_SETTLING)));
        // List exhausted: error with the index equal to the count, then retry
        plan.push_back(mk_checked(KIND_TICK, LINK_IDLE,
            mk_result(1'b0, 3'd2, 1'b0, 1'b0, 1'b0, 1'b1, CODE_ERROR)));
        plan.push_back(mk_beat(KIND_TICK, LINK_IDLE));
        plan.push_back(mk_beat(KIND_TICK, LINK_IDLE));
        plan.push_back(mk_checked(KIND_TICK, LINK_CONNECTED,
            mk_result(1'b1, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, CODE_CONNECTING)));
        plan.push_back(mk_checked(KIND_TICK, LINK_CONNECTED,
            mk_result(1'b0, 3'd0, 1'b0, 1'b1, 1'b0, 1'b0, CODE_CONNECTED)));
        // Loss reported once; link back does not stop the loss timer
        plan.push_back(mk_checked(KIND_TICK, LINK_LOST,
            mk_result(1'b0, 3'd0, 1'b0, 1'b0, 1'b1, 1'b0, CODE_CONNECTED)));
        plan.push_back(mk_beat(KIND_TICK, LINK_CONNECTED));
        plan.push_back(mk_beat(KIND_TICK, LINK_DISCONNECTED));
        plan.push_back(mk_beat(KIND_TICK, LINK_DISCONNECTED));
        plan.push_back(mk_beat(KIND_TICK, LINK_IDLE));
        plan.push_back(mk_checked(KIND_RESTART, LINK_CONNECTED,
            mk_result(1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, CODE_IDLE)));

        // Walk the directed table
        beat_since_reg = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                if (beat_since_reg)
                    wait_quiet();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
                beat_since_reg = 1'b0;
            end
            else
            begin
                send_beat(plan[i].pkt, plan[i].typed, plan[i].want);
                beat_since_reg = 1'b1;
            end
        end

        // Random phases: drain, reprogram, stream ticks and restarts; link status is sticky
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_quiet();
            tx_mode = $urandom_range(0, 2);
            rx_mode = $urandom_range(0, 2);
            beats = PHASE_BEATS;
            if (phase == 0)
            begin
                en = 1'b1;
                nets = 4'd15;
            end
            else if (phase == 1)
            begin
                en = 1'b1;
                nets = 4'(MAX_NETS);
            end
            else if (phase == 2)
            begin
                en = 1'b0;
                nets = 4'($urandom_range(1, 8));
                beats = SHORT_BEATS;
            end
            else if (phase == 4)
            begin
                en = 1'b1;
                nets = 4'd0;
                beats = SHORT_BEATS;
            end
            else
            begin
                en = ($urandom_range(0, 9) != 0);
                case ($urandom_range(0, 9))
                    0:       nets = 4'd0;
                    1:       nets = 4'($urandom_range(9, 15));
                    default: nets = 4'($urandom_range(1, 8));
                endcase
            end
            write_reg(CFG_STA_ENABLE, {31'($urandom()), en});
            write_reg(CFG_NETWORK_COUNT, {28'($urandom()), nets});
            write_reg(CFG_CONNECT_TMO, pick_delay(phase));
            write_reg(CFG_GRACE, pick_delay(phase));
            write_reg(CFG_SETTLE_DELAY, pick_delay(phase));
            write_reg(CFG_RECONNECT_DLY, pick_delay(phase));
            write_reg(CFG_ERROR_RETRY, pick_delay(phase));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, $urandom());
            // back-pressure: sender streams while the result side holds off
            if (phase == HOLD_PHASE)
            begin
                tx_mode = 0;
                rx_hold_req = 1'b1;
            end
            for (n = 0; n < beats; n++)
            begin
                if ($urandom_range(0, 5) == 0)
                    link_now = ($urandom_range(0, 4) < 2) ? LINK_CONNECTED
                                                          : 3'($urandom_range(0, 7));
                pkt.kind = ($urandom_range(0, 49) == 0) ? KIND_RESTART : KIND_TICK;
                pkt.link_status = link_now;
                send_beat(pkt, 1'b0, '0);
            end
        end

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: random or long hold-offs, check every accepted beat
    initial
    begin : result_sink
        result_t seen;
        result_t want;
        int      gap;

        out_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                gap = RX_HOLD_CYCLES;
            end
            else
                gap = draw_gap(rx_mode);
            if (gap > 0)
            begin
                out_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge clk);
            while (!out_bus.valid)
                @(posedge clk);
            seen = mk_result(out_bus.start_attempt, out_bus.attempt_index, out_bus.disconnect_cmd,
                             out_bus.connected_event, out_bus.lost_event, out_bus.error_event,
                             out_bus.state_code);
            if (due_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatch_count++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("start_attempt", int'(want.start_attempt),
                            int'(seen.start_attempt));
                check_field("attempt_index", int'(want.attempt_index),
                            int'(seen.attempt_index));
                check_field("disconnect_cmd", int'(want.disconnect_cmd),
                            int'(seen.disconnect_cmd));
                check_field("connected_event", int'(want.connected_event),
                            int'(seen.connected_event));
                check_field("lost_event", int'(want.lost_event), int'(seen.lost_event));
                check_field("error_event", int'(want.error_event), int'(seen.error_event));
                check_field("state_code", int'(want.state_code), int'(seen.state_code));
            end
        end
    end

    // Watchdog: end the run after too many cycles without any handshake
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
